[hw/rtl/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, constants and helpers for the radix string converter.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int VALUE_W     = 32;
	localparam int CHAR_W      = 8;
	localparam int DIGIT_W     = 4;
	localparam int BASE_W      = 5;
	localparam int ALPHA_N     = 16;
	localparam int MAX_BASE    = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int STACK_DEPTH = VALUE_W;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int STACK_CW    = STACK_AW + 1;
	localparam int DIV_STEPS   = 8;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

	localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_LO  = 3'd0,
		CFG_SRC_HI  = 3'd1,
		CFG_DST_LO  = 3'd2,
		CFG_DST_HI  = 3'd3,
		CFG_SRC_LEN = 3'd4,
		CFG_DST_LEN = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stk_cmd_t;

	function automatic logic [BASE_W-1:0] clamp_len(input logic [BASE_W-1:0] n);
		logic [BASE_W-1:0] r;
		r = n;
		if (n < BASE_W'(2))
			r = BASE_W'(2);
		else if (n > BASE_W'(MAX_BASE))
			r = BASE_W'(MAX_BASE);
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] alpha_char(
		input logic [CFG_DATA_W-1:0] lo,
		input logic [CFG_DATA_W-1:0] hi,
		input logic [DIGIT_W-1:0]    k
	);
		logic [2*CFG_DATA_W-1:0] all;
		all = {hi, lo};
		return all[k*CHAR_W +: CHAR_W];
	endfunction

endpackage

[hw/rtl/rsc_div_unit.sv]
// ----------------------------------------------------------------------------
// rsc_div_unit
// Iterative restoring divider: 32-bit dividend by a radix of up to 16,
// several quotient bits per cycle. Pulses done with quotient and remainder.
// ----------------------------------------------------------------------------
module rsc_div_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rsc_pkg::VALUE_W-1:0]   dividend,
	input  logic [rsc_pkg::BASE_W-1:0]    divisor,
	output logic                          done,
	output logic [rsc_pkg::VALUE_W-1:0]   quotient,
	output logic [rsc_pkg::DIGIT_W-1:0]   remainder
);
	import rsc_pkg::*;

	localparam int NCYC  = VALUE_W / DIV_STEPS;
	localparam int CNT_W = (NCYC > 1) ? $clog2(NCYC) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCYC - 1);

	logic [VALUE_W-1:0] dq_q, dq_n;
	logic [DIGIT_W-1:0] rem_q, rem_n;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q, done_q;

	always_comb begin
		logic [BASE_W-1:0] t;
		dq_n  = dq_q;
		rem_n = rem_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t    = {rem_n, dq_n[VALUE_W-1]};
			dq_n = {dq_n[VALUE_W-2:0], 1'b0};
			if (t >= divisor) begin
				t       = t - divisor;
				dq_n[0] = 1'b1;
			end
			rem_n = t[DIGIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= dq_n;
			rem_q <= rem_n;
		end
	end

	assign done      = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

[hw/rtl/rsc_digit_stack.sv]
// ----------------------------------------------------------------------------
// rsc_digit_stack
// Last-in first-out store for output digits: digits come in least
// significant first and leave most significant first.
// ----------------------------------------------------------------------------
module rsc_digit_stack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rsc_pkg::stk_cmd_t              cmd,
	input  logic [rsc_pkg::DIGIT_W-1:0]    push_digit,
	output logic [rsc_pkg::DIGIT_W-1:0]    top_digit,
	output logic [rsc_pkg::STACK_CW-1:0]   count
);
	import rsc_pkg::*;

	logic [DIGIT_W-1:0]  mem_q [STACK_DEPTH];
	logic [STACK_CW-1:0] cnt_q;
	logic [STACK_CW-1:0] top_idx;

	assign top_idx = cnt_q - STACK_CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.push && cnt_q != STACK_CW'(STACK_DEPTH)) begin
			cnt_q <= cnt_q + STACK_CW'(1);
		end else if (cmd.pop && cnt_q != '0) begin
			cnt_q <= top_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && cnt_q != STACK_CW'(STACK_DEPTH))
			mem_q[cnt_q[STACK_AW-1:0]] <= push_digit;
	end

	assign top_digit = mem_q[top_idx[STACK_AW-1:0]];
	assign count     = cnt_q;

endmodule

[hw/rtl/radix_string_converter_top.sv]
// ----------------------------------------------------------------------------
// radix_string_converter_top
// Number string conversion between two configurable digit alphabets.
// ----------------------------------------------------------------------------
// A string arrives one character per word, an optional leading sign first,
// and each character that is not the last is taken as soon as it is offered.
// The last character starts the conversion: after the setup state the shared
// divider produces the destination digits one at a time, each through a start
// state, the divider's iterations of eight quotient bits each and a wait state
// that stores the digit on done; the sign and digits then leave one word per
// cycle while out_stall is low. The input is stalled from the last character
// until the final output word sits in the output register.
module radix_string_converter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rsc_pkg::CHAR_W-1:0]       in_char,
	input  logic                             in_last,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rsc_pkg::CHAR_W-1:0]       out_char,
	output logic                             out_last,
	input  logic                             cfg_we,
	input  logic [rsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rsc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_START,
		ST_WAIT,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [CFG_DATA_W-1:0] src_lo_q, src_hi_q, dst_lo_q, dst_hi_q;
	logic [BASE_W-1:0]     src_len_q, dst_len_q;

	logic [VALUE_W-1:0] acc_q;
	logic               neg_q, start_q, bad_q;
	logic [VALUE_W-1:0] mag_q;
	logic               sign_pend_q;

	logic               out_valid_q, out_last_q;
	logic [CHAR_W-1:0]  out_char_q;

	logic [BASE_W-1:0]  slen, dlen;
	logic               found;
	logic [DIGIT_W-1:0] pos;
	logic               in_acc, is_sign, out_free, emit_go;
	logic [VALUE_W-1:0] acc_next, val, mag;

	logic               div_done;
	logic [VALUE_W-1:0] div_quot;
	logic [DIGIT_W-1:0] div_rem;

	stk_cmd_t            stk_cmd;
	logic [DIGIT_W-1:0]  stk_top;
	logic [STACK_CW-1:0] stk_cnt;

	assign slen = clamp_len(src_len_q);
	assign dlen = clamp_len(dst_len_q);

	// first match wins: scan from the top so the lowest index lands last
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int k = ALPHA_N - 1; k >= 0; k--) begin
			if (BASE_W'(k) < slen && in_char != CHAR_NUL &&
			    alpha_char(src_lo_q, src_hi_q, DIGIT_W'(k)) == in_char) begin
				found = 1'b1;
				pos   = DIGIT_W'(k);
			end
		end
	end

	assign acc_next = acc_q * VALUE_W'(slen) + VALUE_W'(pos);
	assign in_acc   = in_valid && !in_stall;
	assign is_sign  = start_q && (in_char == CHAR_MINUS || in_char == CHAR_PLUS);
	assign in_stall = (state_q != ST_IDLE);

	assign val = bad_q ? '0 : (neg_q ? (VALUE_W'(0) - acc_q) : acc_q);
	assign mag = val[VALUE_W-1] ? (VALUE_W'(0) - val) : val;

	assign out_free = !out_valid_q || !out_stall;
	assign emit_go  = (state_q == ST_EMIT) && out_free;

	always_comb begin
		stk_cmd.push = (state_q == ST_WAIT) && div_done;
		stk_cmd.pop  = (state_q == ST_EMIT) && out_free && !sign_pend_q;
	end

	rsc_div_unit u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == ST_START),
		.dividend  (mag_q),
		.divisor   (dlen),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	rsc_digit_stack u_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (stk_cmd),
		.push_digit (div_rem),
		.top_digit  (stk_top),
		.count      (stk_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_lo_q  <= '0;
			src_hi_q  <= '0;
			dst_lo_q  <= '0;
			dst_hi_q  <= '0;
			src_len_q <= BASE_RESET;
			dst_len_q <= BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SRC_LO:  src_lo_q  <= cfg_data;
				CFG_SRC_HI:  src_hi_q  <= cfg_data;
				CFG_DST_LO:  dst_lo_q  <= cfg_data;
				CFG_DST_HI:  dst_hi_q  <= cfg_data;
				CFG_SRC_LEN: src_len_q <= cfg_data[BASE_W-1:0];
				CFG_DST_LEN: dst_len_q <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			start_q     <= 1'b1;
			bad_q       <= 1'b0;
			sign_pend_q <= 1'b0;
			mag_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_char_q  <= '0;
		end else begin
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						start_q <= 1'b0;
						if (is_sign)
							neg_q <= (in_char == CHAR_MINUS);
						else if (found)
							acc_q <= acc_next;
						else
							bad_q <= 1'b1;
						if (in_last)
							state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					mag_q       <= mag;
					sign_pend_q <= val[VALUE_W-1];
					acc_q       <= '0;
					neg_q       <= 1'b0;
					start_q     <= 1'b1;
					bad_q       <= 1'b0;
					state_q     <= ST_START;
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						mag_q <= div_quot;
						// stop once the quotient runs out or this digit fills the stack
						if (div_quot == '0 || stk_cnt == STACK_CW'(STACK_DEPTH - 1))
							state_q <= ST_EMIT;
						else
							state_q <= ST_START;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (sign_pend_q) begin
							out_char_q  <= CHAR_MINUS;
							out_last_q  <= 1'b0;
							sign_pend_q <= 1'b0;
						end else begin
							out_char_q <= alpha_char(dst_lo_q, dst_hi_q, stk_top);
							out_last_q <= (stk_cnt == STACK_CW'(1));
							if (stk_cnt == STACK_CW'(1))
								state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

[hw/rtl/rsc_port_checker.sv]
// ----------------------------------------------------------------------------
// rsc_port_checker
// Port-level checks on the converter's handshakes and sequencing.
// ----------------------------------------------------------------------------
module rsc_port_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            in_last,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [rsc_pkg::CHAR_W-1:0]      out_char,
	input logic                            out_last
);
	import rsc_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("output word changed while stalled");

	// a character that is not last leaves the input open
	a_mid_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !in_last |=> !in_stall)
		else $error("input stalled after a mid-string character");

	// the last character closes the input for the conversion
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_last |=> in_stall)
		else $error("input open right after the last character");

	// while the input is open, only a final word can be pending
	a_open_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !(out_valid && !out_last))
		else $error("input open with a mid-string word pending");

endmodule

bind radix_string_converter_top rsc_port_checker u_rsc_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_last   (in_last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_char  (out_char),
	.out_last  (out_last)
);

[bench/rsc_checker.sv]
// ----------------------------------------------------------------------------
// rsc_checker
// Watches the character channels and the register port of the radix string
// converter, predicts every converted string and compares it word by word.
// ----------------------------------------------------------------------------
module rsc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [rsc_pkg::CHAR_W-1:0]     in_char,
	input  logic                           in_last,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [rsc_pkg::CHAR_W-1:0]     out_char,
	input  logic                           out_last,
	input  logic                           cfg_we,
	input  logic [rsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             pending
);
	import rsc_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} out_word_t;

	out_word_t owed_words[$];

	logic [CFG_DATA_W-1:0] src_lo, src_hi, dst_lo, dst_hi;
	logic [BASE_W-1:0]     src_len, dst_len;

	logic [VALUE_W-1:0] accum;
	logic               negative;
	logic               at_start;
	logic               bad_digit;
	int                 errors = 0;

	function automatic int radix_of(input logic [BASE_W-1:0] n);
		if (n < 2)
			return 2;
		if (n > MAX_BASE)
			return MAX_BASE;
		return int'(n);
	endfunction

	function automatic logic [CHAR_W-1:0] glyph(
		input logic [CFG_DATA_W-1:0] lo,
		input logic [CFG_DATA_W-1:0] hi,
		input logic [DIGIT_W-1:0]    k
	);
		logic [2*CFG_DATA_W-1:0] both;
		both = {hi, lo};
		return both[k*CHAR_W +: CHAR_W];
	endfunction

	task automatic clear_string();
		accum = '0;
		negative = 1'b0;
		at_start = 1'b1;
		bad_digit = 1'b0;
	endtask

	// Fold one character into the number; on the last one, owe its conversion.
	task automatic absorb_char(input logic [CHAR_W-1:0] c, input logic l);
		int                 slen;
		int                 dlen;
		int                 pos;
		int                 nd;
		bit                 found;
		bit                 neg;
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] mag;
		logic [DIGIT_W-1:0] digs [VALUE_W];
		out_word_t          w;

		if (at_start && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
			negative = (c == CHAR_MINUS);
			at_start = 1'b0;
		end else begin
			slen = radix_of(src_len);
			at_start = 1'b0;
			found = 1'b0;
			pos = 0;
			if (c != CHAR_NUL) begin
				for (int k = 0; k < slen; k++) begin
					if (!found && glyph(src_lo, src_hi, k[DIGIT_W-1:0]) == c) begin
						found = 1'b1;
						pos = k;
					end
				end
			end
			if (found)
				accum = accum * VALUE_W'(slen) + VALUE_W'(pos);
			else
				bad_digit = 1'b1;
		end

		if (!l)
			return;

		dlen = radix_of(dst_len);
		v = bad_digit ? '0 : (negative ? -accum : accum);
		neg = v[VALUE_W-1];
		mag = neg ? -v : v;
		nd = 0;
		do begin
			digs[nd] = DIGIT_W'(mag % VALUE_W'(dlen));
			mag = mag / VALUE_W'(dlen);
			nd++;
		end while (mag != 0 && nd < VALUE_W);

		if (neg) begin
			w.ch = CHAR_MINUS;
			w.last = 1'b0;
			owed_words.push_back(w);
		end
		for (int j = nd - 1; j >= 0; j--) begin
			w.ch = glyph(dst_lo, dst_hi, digs[j]);
			w.last = (j == 0);
			owed_words.push_back(w);
		end
		clear_string();
	endtask

	task automatic check_word(input logic [CHAR_W-1:0] ch, input logic l);
		out_word_t w;
		if (owed_words.size() == 0) begin
			$display("%0t: expected no word, actual out_char %h out_last %b", $time, ch, l);
			errors++;
		end else begin
			w = owed_words.pop_front();
			if (ch !== w.ch) begin
				$display("%0t: out_char expected %h actual %h", $time, w.ch, ch);
				errors++;
			end
			if (l !== w.last) begin
				$display("%0t: out_last expected %b actual %b", $time, w.last, l);
				errors++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_lo = '0;
			src_hi = '0;
			dst_lo = '0;
			dst_hi = '0;
			src_len = BASE_RESET;
			dst_len = BASE_RESET;
			clear_string();
			owed_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SRC_LO:  src_lo = cfg_data;
					CFG_SRC_HI:  src_hi = cfg_data;
					CFG_DST_LO:  dst_lo = cfg_data;
					CFG_DST_HI:  dst_hi = cfg_data;
					CFG_SRC_LEN: src_len = cfg_data[BASE_W-1:0];
					CFG_DST_LEN: dst_len = cfg_data[BASE_W-1:0];
					default: ;
				endcase
			end
			// Compare first: a result never leaves at the edge its word enters.
			if (out_valid && !out_stall)
				check_word(out_char, out_last);
			if (in_valid && !in_stall)
				absorb_char(in_char, in_last);
		end
		mismatches <= errors;
		pending <= owed_words.size();
	end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives number strings and alphabet settings into the radix string
// converter; a checker beside it predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_top;
	import rsc_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_WORDS = 22;

	typedef enum int {SIGN_NONE, SIGN_PLUS, SIGN_MINUS} sign_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [CHAR_W-1:0]     in_char;
	logic                  in_last;
	logic                  out_valid;
	logic                  out_stall;
	logic [CHAR_W-1:0]     out_char;
	logic                  out_last;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    pending;

	logic [2*CFG_DATA_W-1:0] src_alpha;
	int                      src_radix;
	int                      words_sent = 0;
	int                      idle_cycles = 0;
	bit                      quiet = 1'b0;

	radix_string_converter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_char   (in_char),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.out_last  (out_last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rsc_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_char    (in_char),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.out_last   (out_last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 30);
	end

	// Stop the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_word(input logic [CHAR_W-1:0] c, input logic l);
		in_valid <= 1'b1;
		in_char <= c;
		in_last <= l;
		do @(posedge clk); while (in_stall);
		words_sent++;
		if (!quiet && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		for (int k = 0; k < s.len(); k++)
			send_word(s[k], k == s.len() - 1);
	endtask

	task automatic send_string(input sign_t sign, input int digits, input bit noisy);
		logic [CHAR_W-1:0] c;
		if (sign != SIGN_NONE)
			send_word((sign == SIGN_MINUS) ? CHAR_MINUS : CHAR_PLUS, digits == 0);
		for (int k = 0; k < digits; k++) begin
			c = src_alpha[$urandom_range(src_radix - 1) * CHAR_W +: CHAR_W];
			if (noisy && $urandom_range(2) == 0) begin
				case ($urandom_range(3))
					0: c = CHAR_NUL;
					1: c = CHAR_MINUS;
					2: c = CHAR_PLUS;
					default: c = CHAR_W'($urandom);
				endcase
			end
			send_word(c, k == digits - 1);
		end
	endtask

	// Hold off until every owed word is out, then let the block go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic configure(
		input logic [2*CFG_DATA_W-1:0] src,
		input logic [2*CFG_DATA_W-1:0] dst,
		input logic [BASE_W-1:0]       slen,
		input logic [BASE_W-1:0]       dlen
	);
		write_reg(CFG_SRC_LO, src[CFG_DATA_W-1:0]);
		write_reg(CFG_SRC_HI, src[2*CFG_DATA_W-1:CFG_DATA_W]);
		write_reg(CFG_DST_LO, dst[CFG_DATA_W-1:0]);
		write_reg(CFG_DST_HI, dst[2*CFG_DATA_W-1:CFG_DATA_W]);
		// Upper data bits are junk; only the low five count.
		write_reg(CFG_SRC_LEN, {(CFG_DATA_W-BASE_W)'({$urandom, $urandom}), slen});
		write_reg(CFG_DST_LEN, {(CFG_DATA_W-BASE_W)'({$urandom, $urandom}), dlen});
		cfg_we <= 1'b0;
		src_alpha = src;
		src_radix = (slen < 2) ? 2 : ((slen > MAX_BASE) ? MAX_BASE : slen);
	endtask

	// Distinct nonzero characters; an odd one also gets a duplicate, a '-' and a NUL.
	function automatic logic [2*CFG_DATA_W-1:0] random_alphabet(input bit odd);
		logic [2*CFG_DATA_W-1:0] a;
		logic [CHAR_W-1:0]       c;
		bit                      clash;
		a = '0;
		for (int k = 0; k < ALPHA_N; k++) begin
			do begin
				c = CHAR_W'($urandom_range(1, 255));
				clash = (c == CHAR_MINUS || c == CHAR_PLUS);
				for (int j = 0; j < k; j++)
					if (a[j*CHAR_W +: CHAR_W] == c)
						clash = 1'b1;
			end while (clash);
			a[k*CHAR_W +: CHAR_W] = c;
		end
		if (odd) begin
			a[$urandom_range(3, 15)*CHAR_W +: CHAR_W] = a[$urandom_range(0, 2)*CHAR_W +: CHAR_W];
			a[$urandom_range(1, 15)*CHAR_W +: CHAR_W] = CHAR_MINUS;
			a[$urandom_range(1, 15)*CHAR_W +: CHAR_W] = CHAR_NUL;
		end
		return a;
	endfunction

	initial begin
		logic [BASE_W-1:0] slen;
		logic [BASE_W-1:0] dlen;
		int                target;
		int                pick;
		int                digits;
		sign_t             sign;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_char = '0;
		in_last = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SRC_LO;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Alphabets are all zero bytes after reset: nothing matches.
		send_word("5", 1'b1);
		settle();

		configure("fedcba9876543210", "FEDCBA9876543210", 5'd16, 5'd2);
		send_text("-80000000");
		send_text("ffffffff");
		send_text("+");
		send_text("-");
		send_text("1-");
		send_word(CHAR_NUL, 1'b1);
		send_text("+5");
		settle();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin slen = 5'd2; dlen = 5'd16; end
				1: begin slen = 5'd16; dlen = 5'd2; end
				2: begin slen = 5'd1; dlen = 5'd31; end
				3: begin slen = 5'd0; dlen = 5'd17; end
				default: begin
					slen = BASE_W'($urandom_range(2, 16));
					dlen = BASE_W'($urandom_range(2, 16));
				end
			endcase
			configure(random_alphabet(phase[0]), random_alphabet(phase == 3), slen, dlen);
			quiet = (phase == 4);
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				pick = $urandom_range(9);
				if (pick == 0) begin
					send_string(SIGN_NONE, $urandom_range(1, 6), 1'b1);
				end else if (pick == 1) begin
					send_string($urandom_range(1) ? SIGN_MINUS : SIGN_PLUS, 0, 1'b0);
				end else begin
					sign = sign_t'($urandom_range(2));
					digits = ($urandom_range(4) == 0) ? $urandom_range(9, 14)
						: $urandom_range(1, 8);
					send_string(sign, digits, 1'b0);
				end
			end
			settle();
		end

		quiet = 1'b0;
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
